FILE: hw/rtl/rc4d_pkg.sv
`default_nettype none

package rc4d_pkg;

   // input item kinds
   typedef enum logic [1:0] {
      KIND_KEY    = 2'd0,
      KIND_STREAM = 2'd1,
      KIND_RESET  = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   // frame header layout
   localparam int unsigned HEADER_BYTES = 13;
   localparam int unsigned LENGTH_BYTES = 4;
   localparam int unsigned LENGTH_BIAS  = 9;

   // s-box write port
   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } sbox_wr_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rc4d_sbox_ram.sv
`default_nettype none

module rc4d_sbox_ram (
   input  wire logic                 clock,
   input  wire rc4d_pkg::sbox_wr_type wr,
   input  wire logic [7:0]           rd_addr,
   output logic [7:0]                rd_data
);
   import rc4d_pkg::*;

   logic [7:0] sbox_mem [256];
   logic [7:0] rd_q_ff;
   logic       fwd_hit_ff;
   logic [7:0] fwd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         sbox_mem[wr.addr] <= wr.data;
      end
      rd_q_ff     <= sbox_mem[rd_addr];
      fwd_hit_ff  <= wr.en && (wr.addr == rd_addr);
      fwd_data_ff <= wr.data;
   end

   // write-first: a read of the entry written in the same cycle sees the new value
   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_q_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/length_framed_rc4_stream_decryptor.sv
// Payload byte: PJ reads s[j], PT writes s[i], PW writes s[j] and registers the
// result or holds it in HOLD; the single s-box read port (reads at i, j, i+j)
// paces them, and the next may transfer in PW. Header, key and unused bytes: one
// per cycle while idle. Final key byte: req_stall high through the identity fill,
// KA, and KB, KC, KD per s-box entry. Reset and session reset: identity fill,
// req_stall high. Reset is synchronous, active high; the key store is not cleared.
`default_nettype none

module length_framed_rc4_stream_decryptor #(
   parameter int unsigned KEY_DEPTH = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_kind,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_key_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_plain_byte,
   output logic            rsp_frame_last
);
   import rc4d_pkg::*;

   localparam int unsigned KLEN_W = $clog2(KEY_DEPTH + 1);
   localparam int unsigned KIDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_PJ, ST_PT, ST_PW, ST_HOLD, ST_KA, ST_KB, ST_KC, ST_KD
   } state_type;

   state_type           state_ff, state_in;
   logic [7:0]          cnt_ff, cnt_in;
   logic                ksa_pend_ff, ksa_pend_in;
   logic [KLEN_W-1:0]   key_len_ff, key_len_in;
   logic [KLEN_W-1:0]   ksa_len_ff, ksa_len_in;
   logic [KIDX_W-1:0]   kidx_ff, kidx_in;
   logic [7:0]          i_ff, i_in;
   logic [7:0]          j_ff, j_in;
   logic [7:0]          si_ff, si_in;
   logic [7:0]          t_ff, t_in;
   logic [7:0]          data_ff, data_in;
   logic                last_ff, last_in;
   logic [3:0]          hdr_pos_ff, hdr_pos_in;
   logic [31:0]         len_acc_ff, len_acc_in;
   logic [31:0]         remain_ff, remain_in;
   logic [7:0]          hold_plain_ff, hold_plain_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_plain_ff, rsp_plain_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [7:0]          key_mem [KEY_DEPTH];
   logic [7:0]          key_rd_ff;
   logic [KIDX_W-1:0]   key_rd_addr;
   logic                key_wr_en;
   logic [KIDX_W-1:0]   key_wr_addr;
   logic [KLEN_W-1:0]   key_len_after;
   logic [KIDX_W-1:0]   kidx_next;

   sbox_wr_type         sb_wr;
   logic [7:0]          sb_rd_addr;
   logic [7:0]          sb_rd_data;
   logic [7:0]          jn;
   logic [7:0]          keystream;
   logic [7:0]          plain;
   logic [31:0]         len_now;
   logic                out_free;
   logic                req_accept;

   rc4d_sbox_ram u_sbox (
      .clock   (clock),
      .wr      (sb_wr),
      .rd_addr (sb_rd_addr),
      .rd_data (sb_rd_data)
   );

   // key store
   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_mem[key_wr_addr] <= req_data_byte;
      end
      key_rd_ff <= key_mem[key_rd_addr];
   end

   // handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) || ((state_ff == ST_PW) && out_free));
   assign req_accept = req_valid && !req_stall;

   // keystream byte; the s[j] write is still in flight when s[i+j] arrives
   assign keystream = (t_ff == j_ff) ? si_ff : sb_rd_data;
   assign plain     = data_ff ^ keystream;

   // header length lane insert
   assign len_now = (hdr_pos_ff < 4'(LENGTH_BYTES))
                  ? (len_acc_ff | (32'(req_data_byte) << {hdr_pos_ff[1:0], 3'b000}))
                  : len_acc_ff;

   assign kidx_next = ((KLEN_W'(kidx_ff) + KLEN_W'(1)) == ksa_len_ff)
                    ? '0 : kidx_ff + KIDX_W'(1);
   assign key_len_after = (key_len_ff < KLEN_W'(KEY_DEPTH))
                        ? key_len_ff + KLEN_W'(1) : key_len_ff;
   assign jn = j_ff + sb_rd_data;

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ksa_pend_in   = ksa_pend_ff;
      key_len_in    = key_len_ff;
      ksa_len_in    = ksa_len_ff;
      kidx_in       = kidx_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      si_in         = si_ff;
      t_in          = t_ff;
      data_in       = data_ff;
      last_in       = last_ff;
      hdr_pos_in    = hdr_pos_ff;
      len_acc_in    = len_acc_ff;
      remain_in     = remain_ff;
      hold_plain_in = hold_plain_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_plain_in  = rsp_plain_ff;
      rsp_last_in   = rsp_last_ff;
      sb_wr         = '0;
      sb_rd_addr    = i_ff + 8'd1;
      key_rd_addr   = kidx_ff;
      key_wr_en     = 1'b0;
      key_wr_addr   = key_len_ff[KIDX_W-1:0];

      case (state_ff)
         // identity fill, one entry per cycle
         ST_INIT: begin
            sb_wr.en   = 1'b1;
            sb_wr.addr = cnt_ff;
            sb_wr.data = cnt_ff;
            cnt_in     = cnt_ff + 8'd1;
            if (cnt_ff == 8'hFF) begin
               if (ksa_pend_ff) begin
                  state_in = ST_KA;
                  j_in     = '0;
                  kidx_in  = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         // key schedule: read s[n] and key byte
         ST_KA: begin
            sb_rd_addr  = cnt_ff;
            key_rd_addr = kidx_ff;
            state_in    = ST_KB;
         end
         ST_KB: begin
            j_in       = j_ff + sb_rd_data + key_rd_ff;
            sb_rd_addr = j_ff + sb_rd_data + key_rd_ff;
            si_in      = sb_rd_data;
            state_in   = ST_KC;
         end
         ST_KC: begin
            sb_wr.en   = 1'b1;
            sb_wr.addr = cnt_ff;
            sb_wr.data = sb_rd_data;
            state_in   = ST_KD;
         end
         // finish swap and fetch the next entry in the same cycle
         ST_KD: begin
            sb_wr.en   = 1'b1;
            sb_wr.addr = j_ff;
            sb_wr.data = si_ff;
            if (cnt_ff == 8'hFF) begin
               state_in    = ST_IDLE;
               cnt_in      = '0;
               i_in        = '0;
               j_in        = '0;
               ksa_pend_in = 1'b0;
            end else begin
               cnt_in      = cnt_ff + 8'd1;
               kidx_in     = kidx_next;
               sb_rd_addr  = cnt_ff + 8'd1;
               key_rd_addr = kidx_next;
               state_in    = ST_KB;
            end
         end
         // keystream: s[i] is back, fetch s[j]
         ST_PJ: begin
            j_in       = jn;
            sb_rd_addr = jn;
            si_in      = sb_rd_data;
            state_in   = ST_PT;
         end
         // write s[i] and fetch s[s[i] + s[j]]
         ST_PT: begin
            sb_wr.en   = 1'b1;
            sb_wr.addr = i_ff;
            sb_wr.data = sb_rd_data;
            sb_rd_addr = si_ff + sb_rd_data;
            t_in       = si_ff + sb_rd_data;
            state_in   = ST_PW;
         end
         // write s[j] and deliver the plain byte, or hold it while the output is occupied
         ST_PW: begin
            sb_wr.en   = 1'b1;
            sb_wr.addr = j_ff;
            sb_wr.data = si_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_plain_in = plain;
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end else begin
               hold_plain_in = plain;
               state_in      = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_plain_in = hold_plain_ff;
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      // input transfer
      if (req_accept) begin
         case (req_kind)
            KIND_KEY: begin
               key_wr_en  = (key_len_ff < KLEN_W'(KEY_DEPTH));
               key_len_in = key_len_after;
               state_in   = ST_IDLE;
               if (req_key_last) begin
                  ksa_len_in  = key_len_after;
                  key_len_in  = '0;
                  ksa_pend_in = 1'b1;
                  cnt_in      = '0;
                  i_in        = '0;
                  j_in        = '0;
                  hdr_pos_in  = '0;
                  len_acc_in  = '0;
                  remain_in   = '0;
                  state_in    = ST_INIT;
               end
            end
            KIND_STREAM: begin
               if (remain_ff != '0) begin
                  remain_in = remain_ff - 32'd1;
                  last_in   = (remain_ff == 32'd1);
                  data_in   = req_data_byte;
                  i_in      = i_ff + 8'd1;
                  state_in  = ST_PJ;
               end else begin
                  state_in = ST_IDLE;
                  if (hdr_pos_ff == 4'(HEADER_BYTES - 1)) begin
                     remain_in  = (len_now > 32'(LENGTH_BIAS))
                                ? len_now - 32'(LENGTH_BIAS) : '0;
                     hdr_pos_in = '0;
                     len_acc_in = '0;
                  end else begin
                     hdr_pos_in = hdr_pos_ff + 4'd1;
                     len_acc_in = len_now;
                  end
               end
            end
            KIND_RESET: begin
               key_len_in  = '0;
               ksa_pend_in = 1'b0;
               cnt_in      = '0;
               i_in        = '0;
               j_in        = '0;
               hdr_pos_in  = '0;
               len_acc_in  = '0;
               remain_in   = '0;
               state_in    = ST_INIT;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         ksa_pend_ff  <= 1'b0;
         key_len_ff   <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         hdr_pos_ff   <= '0;
         len_acc_ff   <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         ksa_pend_ff   <= ksa_pend_in;
         key_len_ff    <= key_len_in;
         ksa_len_ff    <= ksa_len_in;
         kidx_ff       <= kidx_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         si_ff         <= si_in;
         t_ff          <= t_in;
         data_ff       <= data_in;
         last_ff       <= last_in;
         hdr_pos_ff    <= hdr_pos_in;
         len_acc_ff    <= len_acc_in;
         remain_ff     <= remain_in;
         hold_plain_ff <= hold_plain_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_plain_ff  <= rsp_plain_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_plain_byte = rsp_plain_ff;
   assign rsp_frame_last = rsp_last_ff;

`ifndef SYNTHESIS
   // keystream work starts only from a payload transfer
   a_pj_after_transfer: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PJ |-> $past(req_accept))
      else $error("keystream step without a payload transfer");

   // key length never passes the store depth
   a_key_len_bound: assert property (@(posedge clock) disable iff (reset)
      key_len_ff <= KLEN_W'(KEY_DEPTH))
      else $error("key length beyond key store");

   // a byte marked last leaves no payload in the frame
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PJ) && last_ff |-> remain_ff == '0)
      else $error("frame end with payload still due");

   // a held result means the output register is occupied
   a_hold_occupied: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HOLD |-> rsp_valid_ff)
      else $error("held result with empty output register");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rc4d_pkg::*;

   localparam int unsigned KEY_SLOTS = 256;

   typedef struct {
      kind_type   kind;
      logic [7:0] data_byte;
      logic       key_last;
      bit         hold;
   } req_item_type;

   typedef struct {
      logic [7:0] plain;
      logic       last;
   } plain_rec_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_kind = KIND_UNUSED;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_key_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_plain_byte;
   logic       rsp_frame_last;

   // pending input items and expected plaintext
   req_item_type  pending_q[$];
   plain_rec_type plain_q[$];
   int unsigned queued_count = 0;
   int unsigned stream_items = 0;
   int unsigned accepted_count = 0;
   int unsigned mismatch_count = 0;
   bit          hold_next = 1'b0;
   logic        req_taken = 1'b0;

   // predictor state
   logic [7:0]  rc4_sbox [256];
   logic [7:0]  key_bytes [KEY_SLOTS];
   int unsigned key_count;
   logic [7:0]  ks_i;
   logic [7:0]  ks_j;
   logic [3:0]  hdr_count;
   logic [31:0] hdr_length;
   logic [32:0] payload_left;

   length_framed_rc4_stream_decryptor u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_data_byte  (req_data_byte),
      .req_key_last   (req_key_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_plain_byte (rsp_plain_byte),
      .rsp_frame_last (rsp_frame_last)
   );

   // clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // whole session back to power-up state; key bytes are kept
   function automatic void clear_session();
      for (int n = 0; n < 256; n++) rc4_sbox[n] = n[7:0];
      key_count    = 0;
      ks_i         = 8'd0;
      ks_j         = 8'd0;
      hdr_count    = 4'd0;
      hdr_length   = 32'd0;
      payload_left = 33'd0;
   endfunction

   // advance the decryptor model by one accepted transfer
   task automatic decrypt_step(input req_item_type item);
      logic [7:0]    t;
      logic [7:0]    jj;
      int unsigned   klen;
      plain_rec_type rec;
      case (item.kind)
         KIND_KEY: begin
            // key bytes beyond the store are dropped
            if (key_count < KEY_SLOTS) begin
               key_bytes[key_count] = item.data_byte;
               key_count++;
            end
            if (item.key_last) begin
               klen = (key_count == 0) ? 1 : key_count;
               for (int n = 0; n < 256; n++) rc4_sbox[n] = n[7:0];
               jj = 8'd0;
               for (int n = 0; n < 256; n++) begin
                  jj = jj + rc4_sbox[n] + key_bytes[n % klen];
                  t = rc4_sbox[n];
                  rc4_sbox[n] = rc4_sbox[jj];
                  rc4_sbox[jj] = t;
               end
               ks_i         = 8'd0;
               ks_j         = 8'd0;
               key_count    = 0;
               hdr_count    = 4'd0;
               hdr_length   = 32'd0;
               payload_left = 33'd0;
            end
         end
         KIND_RESET: clear_session();
         KIND_STREAM: begin
            if (payload_left != 0) begin
               // payload byte: xor with next keystream byte
               ks_i = ks_i + 8'd1;
               ks_j = ks_j + rc4_sbox[ks_i];
               t = rc4_sbox[ks_i];
               rc4_sbox[ks_i] = rc4_sbox[ks_j];
               rc4_sbox[ks_j] = t;
               jj = rc4_sbox[ks_i] + rc4_sbox[ks_j];
               payload_left = payload_left - 33'd1;
               rec.plain = item.data_byte ^ rc4_sbox[jj];
               rec.last  = (payload_left == 0);
               plain_q.push_back(rec);
            end else begin
               // header byte: first four carry the little-endian length
               if (hdr_count < LENGTH_BYTES)
                  hdr_length = hdr_length | (32'(item.data_byte) << (8 * hdr_count));
               hdr_count = hdr_count + 4'd1;
               if (hdr_count >= HEADER_BYTES) begin
                  payload_left = (hdr_length > LENGTH_BIAS) ?
                                 {1'b0, hdr_length} - 33'(LENGTH_BIAS) : 33'd0;
                  hdr_count  = 4'd0;
                  hdr_length = 32'd0;
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t mismatch on %s: got %02h, expected %02h", $time, what, got, want);
      mismatch_count++;
   endtask

   // mostly short gaps, a few long ones, none in calm stretches
   function automatic int unsigned pick_gap(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // queue one item, with an occasional unused-kind item ahead of it as noise
   task automatic queue_item(input kind_type kind, input logic [7:0] data,
                             input logic last);
      req_item_type item;
      if ($urandom_range(0, 49) == 0) begin
         item.kind      = KIND_UNUSED;
         item.data_byte = 8'($urandom);
         item.key_last  = 1'($urandom);
         item.hold      = 1'b0;
         pending_q.push_back(item);
         queued_count++;
      end
      item.kind      = kind;
      item.data_byte = data;
      item.key_last  = last;
      item.hold      = hold_next;
      hold_next      = 1'b0;
      pending_q.push_back(item);
      queued_count++;
      if (kind != KIND_UNUSED) stream_items++;
   endtask

   // header with the given length, random filler, then payload_n random bytes
   task automatic queue_frame(input logic [31:0] len, input int unsigned payload_n);
      for (int k = 0; k < HEADER_BYTES; k++)
         queue_item(KIND_STREAM, (k < LENGTH_BYTES) ? len[8*k +: 8] : 8'($urandom),
                    1'($urandom));
      for (int k = 0; k < payload_n; k++)
         queue_item(KIND_STREAM, 8'($urandom), 1'($urandom));
   endtask

   task automatic queue_key(input int unsigned n);
      for (int k = 0; k < n; k++)
         queue_item(KIND_KEY, 8'($urandom), k == n - 1);
   endtask

   // driver: next item once the current one has transferred
   always @(negedge clock) begin : driver
      req_item_type nxt;
      int unsigned  send_gap;
      bit           send_calm;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
         send_calm = 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap  = send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_q.size() > 0 && !(pending_q[0].hold && plain_q.size() > 0)) begin
            nxt = pending_q.pop_front();
            req_kind      <= nxt.kind;
            req_data_byte <= nxt.data_byte;
            req_key_last  <= nxt.key_last;
            req_valid     <= 1'b1;
            if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
            send_gap = pick_gap(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin : receiver
      int unsigned stall_left;
      bit          recv_calm;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
         recv_calm  = 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 299) == 0) recv_calm = !recv_calm;
         stall_left = pick_gap(recv_calm);
      end
   end

   // monitor: predict on input transfers, check result transfers
   always @(posedge clock) begin : monitor
      req_item_type  seen;
      plain_rec_type want;
      if (reset) begin
         req_taken <= 1'b0;
         clear_session();
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            seen.kind      = kind_type'(req_kind);
            seen.data_byte = req_data_byte;
            seen.key_last  = req_key_last;
            seen.hold      = 1'b0;
            decrypt_step(seen);
            accepted_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (plain_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_plain_byte, 8'h00);
            end else begin
               want = plain_q.pop_front();
               if (rsp_plain_byte !== want.plain)
                  report_mismatch("plain_byte", rsp_plain_byte, want.plain);
               if (rsp_frame_last !== want.last)
                  report_mismatch("frame_last", 8'(rsp_frame_last), 8'(want.last));
            end
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int unsigned r;
      int unsigned sessions;
      int unsigned len;
      // directed: ignored kind, frame before any key, key extremes, session reset
      queue_item(KIND_UNUSED, 8'hFF, 1'b1);
      queue_frame(32'd10, 1);
      queue_item(KIND_KEY, 8'hFF, 1'b1);
      queue_item(KIND_RESET, 8'h00, 1'b0);
      queue_item(KIND_KEY, 8'h00, 1'b1);

      // random sessions: key load or session reset, frames, sometimes a broken tail
      sessions = 0;
      while (stream_items < 2000) begin
         if (sessions % 8 == 1) hold_next = 1'b1;
         r = $urandom_range(0, 9);
         if (sessions == 3 || sessions == 11) queue_key($urandom_range(256, 300));
         else if (r < 7) queue_key($urandom_range(1, 16));
         else if (r < 8) queue_key($urandom_range(17, 64));
         else queue_item(KIND_RESET, 8'($urandom), 1'($urandom));
         for (int f = $urandom_range(1, 4); f > 0; f--) begin
            r = $urandom_range(0, 19);
            if (r < 2) len = $urandom_range(0, 9);
            else if (r < 3) len = 10;
            else len = $urandom_range(10, 60);
            queue_frame(len, (len > LENGTH_BIAS) ? len - LENGTH_BIAS : 0);
         end
         r = $urandom_range(0, 7);
         if (r == 0) begin
            // huge length, cut short by the next session start
            queue_frame($urandom | 32'h0100_0000, $urandom_range(0, 20));
         end else if (r == 1) begin
            // partial header
            for (int k = $urandom_range(1, 12); k > 0; k--)
               queue_item(KIND_STREAM, 8'($urandom), 1'($urandom));
         end
         sessions++;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_count != queued_count || plain_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("length_framed_rc4_stream_decryptor regression: pass");
      else
         $display("length_framed_rc4_stream_decryptor regression: fail");
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("length_framed_rc4_stream_decryptor regression: fail");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/rc4d_pkg.sv
hw/rtl/rc4d_sbox_ram.sv
hw/rtl/length_framed_rc4_stream_decryptor.sv
tb/sv/tb_top.sv
